/* hw/rtl/ste_pkg.sv */
package ste_pkg;

	// Field widths of the request and response beats.
	localparam int unsigned OP_W  = 2;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned IDX_W = 5;
	localparam int unsigned ST_W  = 3;
	localparam int unsigned CNT_W = 5;

	// Operation codes carried in the request beat.
	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_MODIFY = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	// Status codes carried in the response beat.
	typedef enum logic [ST_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_BAD_INDEX = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture the request beat
		logic init;     // prepare a table walk
		logic quick;    // finish an operation that needs no walk
		logic scan;     // advance the table walk
		logic publish;  // move the result into the response register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic quick;    // the captured operation finishes without a walk
		logic done;     // the walk completes in this cycle
	} dp_stat_t;

endpackage

/* hw/rtl/ste_req_if.sv */
interface ste_req_if;

	logic                              valid;
	logic                              ready;
	logic [ste_pkg::OP_W-1:0]          op;
	logic signed [ste_pkg::VAL_W-1:0]  value;
	logic [ste_pkg::IDX_W-1:0]         index;

	modport source (output valid, output op, output value, output index, input ready);
	modport sink (input valid, input op, input value, input index, output ready);

endinterface

/* hw/rtl/ste_rsp_if.sv */
interface ste_rsp_if;

	logic                      valid;
	logic                      ready;
	logic [ste_pkg::ST_W-1:0]  status;
	logic [ste_pkg::CNT_W-1:0] position;
	logic [ste_pkg::CNT_W-1:0] removed;
	logic [ste_pkg::CNT_W-1:0] count;

	modport source (output valid, output status, output position, output removed,
		output count, input ready);
	modport sink (input valid, input status, input position, input removed,
		input count, output ready);

endinterface

/* hw/rtl/ste_datapath.sv */
module ste_datapath #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ste_pkg::cmd_t                     cmd,
	output ste_pkg::dp_stat_t                 stat,
	input  logic [ste_pkg::OP_W-1:0]          in_op,
	input  logic signed [ste_pkg::VAL_W-1:0]  in_value,
	input  logic [ste_pkg::IDX_W-1:0]         in_index,
	output logic [ste_pkg::ST_W-1:0]          status,
	output logic [ste_pkg::CNT_W-1:0]         position,
	output logic [ste_pkg::CNT_W-1:0]         removed,
	output logic [ste_pkg::CNT_W-1:0]         count
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned LW = (CW > ste_pkg::IDX_W) ? CW : ste_pkg::IDX_W;
	localparam int unsigned OW = (CW > ste_pkg::CNT_W) ? CW : ste_pkg::CNT_W;

	// Table storage with one write port and one registered read port.
	logic signed [ste_pkg::VAL_W-1:0] mem_q [DEPTH];
	logic signed [ste_pkg::VAL_W-1:0] rdata_s1;

	// Captured request.
	ste_pkg::op_t                     op_q;
	logic signed [ste_pkg::VAL_W-1:0] val_q;
	logic [ste_pkg::IDX_W-1:0]        idx_q;

	// Walk state.
	logic [CW-1:0] fill_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] wr_q;
	logic [CW-1:0] rem_q;
	logic          issue_end_q;
	logic          pend_s1;
	logic [CW-1:0] posn_s1;

	// Pending result and response register.
	ste_pkg::status_t          res_status_q;
	logic [CW-1:0]             res_pos_q;
	logic [CW-1:0]             res_rem_q;
	logic [ste_pkg::ST_W-1:0]  out_status_q;
	logic [ste_pkg::CNT_W-1:0] out_pos_q;
	logic [ste_pkg::CNT_W-1:0] out_rem_q;
	logic [ste_pkg::CNT_W-1:0] out_cnt_q;

	logic                             we;
	logic [AW-1:0]                    waddr;
	logic signed [ste_pkg::VAL_W-1:0] wdata;
	logic [AW-1:0]                    raddr;
	logic                             proc_done;
	logic                             issue_en;
	logic                             quick;
	logic                             idx_ok;
	logic                             is_last;
	logic                             gt;
	logic                             eq;
	logic [CW-1:0]                    rem_tot;
	logic [LW-1:0]                    fill_ext;
	logic [LW-1:0]                    idx_ext;
	logic [LW-1:0]                    idx_m1;
	logic [OW-1:0]                    pos_w;
	logic [OW-1:0]                    rem_w;
	logic [OW-1:0]                    cnt_w;

	// Comparisons against the captured value.
	assign fill_ext = LW'(fill_q);
	assign idx_ext  = LW'(idx_q);
	assign idx_m1   = idx_ext - LW'(1);
	assign idx_ok   = (idx_ext != '0) && (idx_ext <= fill_ext);
	assign is_last  = (posn_s1 == (fill_q - CW'(1)));
	assign gt       = (rdata_s1 > val_q);
	assign eq       = (rdata_s1 == val_q);
	assign rem_tot  = rem_q + (eq ? CW'(1) : CW'(0));

	// Operations that finish without walking the table.
	always_comb begin
		unique case (op_q)
			ste_pkg::OP_INSERT: quick = (fill_q == CW'(DEPTH));
			ste_pkg::OP_DELETE: quick = (fill_q == '0);
			ste_pkg::OP_MODIFY: quick = 1'b1;
			ste_pkg::OP_QUERY:  quick = (fill_q == '0);
			default:            quick = 1'b1;
		endcase
	end

	// Write port selection and completion of the walk.
	always_comb begin
		we        = 1'b0;
		waddr     = '0;
		wdata     = val_q;
		proc_done = 1'b0;
		if (cmd.quick && (op_q == ste_pkg::OP_MODIFY) && idx_ok) begin
			we    = 1'b1;
			waddr = AW'(idx_m1);
		end else if (pend_s1) begin
			unique case (op_q)
				ste_pkg::OP_INSERT: begin
					// Move larger entries up; the value lands just above the first
					// entry that is not greater, or at the bottom.
					we    = 1'b1;
					waddr = AW'(posn_s1);
					if ((posn_s1 != '0) && gt) begin
						wdata = rdata_s1;
					end else begin
						proc_done = 1'b1;
					end
				end
				ste_pkg::OP_DELETE: begin
					// Keep unequal entries, packed down to the write pointer.
					if (!eq) begin
						we    = 1'b1;
						waddr = AW'(wr_q);
						wdata = rdata_s1;
					end
					proc_done = is_last;
				end
				ste_pkg::OP_QUERY: begin
					proc_done = eq || is_last;
				end
				default: begin
					proc_done = 1'b1;
				end
			endcase
		end
	end

	assign issue_en = cmd.scan && !issue_end_q && !proc_done;

	// Insert reads one entry below the position it may write.
	always_comb begin
		if (op_q == ste_pkg::OP_INSERT) begin
			raddr = (ptr_q == '0) ? '0 : AW'(ptr_q - CW'(1));
		end else begin
			raddr = AW'(ptr_q);
		end
	end

	// Table memory.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_s1 <= mem_q[raddr];
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= ste_pkg::op_t'(in_op);
			val_q <= in_value;
			idx_q <= in_index;
		end
	end

	// Walk control, fill count and pending result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			ptr_q        <= '0;
			wr_q         <= '0;
			rem_q        <= '0;
			issue_end_q  <= 1'b0;
			pend_s1      <= 1'b0;
			posn_s1      <= '0;
			res_status_q <= ste_pkg::ST_OK;
			res_pos_q    <= '0;
			res_rem_q    <= '0;
		end else begin
			if (cmd.init) begin
				ptr_q       <= (op_q == ste_pkg::OP_INSERT) ? fill_q : '0;
				wr_q        <= '0;
				rem_q       <= '0;
				issue_end_q <= 1'b0;
				pend_s1     <= 1'b0;
			end
			if (cmd.quick) begin
				res_pos_q <= '0;
				res_rem_q <= '0;
				unique case (op_q)
					ste_pkg::OP_INSERT: res_status_q <= ste_pkg::ST_FULL;
					ste_pkg::OP_DELETE: res_status_q <= ste_pkg::ST_EMPTY;
					ste_pkg::OP_MODIFY: res_status_q <= idx_ok ? ste_pkg::ST_OK
						: ste_pkg::ST_BAD_INDEX;
					ste_pkg::OP_QUERY:  res_status_q <= ste_pkg::ST_NOT_FOUND;
					default:            res_status_q <= ste_pkg::ST_NOT_FOUND;
				endcase
			end
			if (cmd.scan) begin
				// Issue side: one read per cycle.
				pend_s1 <= issue_en;
				posn_s1 <= ptr_q;
				if (issue_en) begin
					if (op_q == ste_pkg::OP_INSERT) begin
						ptr_q       <= ptr_q - CW'(1);
						issue_end_q <= (ptr_q == '0);
					end else begin
						ptr_q       <= ptr_q + CW'(1);
						issue_end_q <= (ptr_q == (fill_q - CW'(1)));
					end
				end
				// Process side: counters of the delete compaction.
				if (pend_s1 && (op_q == ste_pkg::OP_DELETE)) begin
					if (eq) begin
						rem_q <= rem_q + CW'(1);
					end else begin
						wr_q <= wr_q + CW'(1);
					end
				end
				if (proc_done) begin
					res_pos_q <= '0;
					res_rem_q <= '0;
					unique case (op_q)
						ste_pkg::OP_INSERT: begin
							res_status_q <= ste_pkg::ST_OK;
							fill_q       <= fill_q + CW'(1);
						end
						ste_pkg::OP_DELETE: begin
							res_rem_q    <= rem_tot;
							fill_q       <= fill_q - rem_tot;
							res_status_q <= (rem_tot == '0) ? ste_pkg::ST_NOT_FOUND
								: ste_pkg::ST_OK;
						end
						ste_pkg::OP_QUERY: begin
							res_status_q <= eq ? ste_pkg::ST_OK : ste_pkg::ST_NOT_FOUND;
							res_pos_q    <= eq ? (posn_s1 + CW'(1)) : '0;
						end
						default: begin
							res_status_q <= ste_pkg::ST_OK;
						end
					endcase
				end
			end
		end
	end

	// Response register, loaded when the response side has room.
	assign pos_w = OW'(res_pos_q);
	assign rem_w = OW'(res_rem_q);
	assign cnt_w = OW'(fill_q);

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_status_q <= res_status_q;
			out_pos_q    <= pos_w[ste_pkg::CNT_W-1:0];
			out_rem_q    <= rem_w[ste_pkg::CNT_W-1:0];
			out_cnt_q    <= cnt_w[ste_pkg::CNT_W-1:0];
		end
	end

	assign stat.quick = quick;
	assign stat.done  = proc_done;
	assign status     = out_status_q;
	assign position   = out_pos_q;
	assign removed    = out_rem_q;
	assign count      = out_cnt_q;

endmodule

/* hw/rtl/ste_ctrl.sv */
module ste_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ste_pkg::dp_stat_t stat,
	output ste_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Commands follow from the state and the datapath status.
	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == S_IDLE) && in_valid;
		cmd.quick   = (state_q == S_DECIDE) && stat.quick;
		cmd.init    = (state_q == S_DECIDE) && !stat.quick;
		cmd.scan    = (state_q == S_SCAN);
		cmd.publish = (state_q == S_FIN) && out_free;
	end

	// State and response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q <= stat.quick ? S_FIN : S_SCAN;
				end
				S_SCAN: begin
					if (stat.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/sorted_table_engine_top.sv */
// Sorted table engine: keeps up to DEPTH signed 32-bit values in ascending order
// (a modify can break the order) and answers one request beat (insert, delete,
// modify or query) with one response beat carrying status, query position, delete
// count and the fill count afterwards. One request is worked on at a time. Modify,
// and any request that is refused at once (insert into a full table, delete or
// query on an empty one), is answered without a table walk. Insert, delete and
// query walk the table through the single read and single write port of the table
// memory, one entry per cycle. Insert walks from the top down to its slot, delete
// walks every entry, and query stops at the first match. A result is not published
// while an earlier response beat still waits to be taken. Request acceptance
// resumes right after the response is registered, even while that response beat
// still waits to be taken. The table contents are not cleared at reset.
module sorted_table_engine_top #(
	parameter int unsigned DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	ste_req_if.sink   req,
	ste_rsp_if.source rsp
);

	ste_pkg::cmd_t     cmd;
	ste_pkg::dp_stat_t stat;

	ste_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ste_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_op    (req.op),
		.in_value (req.value),
		.in_index (req.index),
		.status   (rsp.status),
		.position (rsp.position),
		.removed  (rsp.removed),
		.count    (rsp.count)
	);

	// At most one command is issued per cycle.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.init, cmd.quick, cmd.scan, cmd.publish}))
		else $error("controller issued more than one command");

	// A result is only published when the response register has room.
	a_publish_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!rsp.valid || rsp.ready))
		else $error("result published over an untaken response beat");

	// The walk reports completion only while it is running.
	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> cmd.scan)
		else $error("walk completion outside the walk");

	// After a request is accepted, no further request is taken in the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while another is in progress");

endmodule

/* verif/ste_table_checker.sv */
`timescale 1ns / 100ps

// Watches the request and response channels, keeps its own copy of the sorted table,
// and compares every response beat with the answer predicted for the oldest request.
module ste_table_checker #(
	parameter int unsigned DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ste_req_if          req,
	ste_rsp_if          rsp,
	output int unsigned fail_count,
	output int unsigned outstanding
);

	typedef struct packed {
		ste_pkg::status_t          status;
		logic [ste_pkg::CNT_W-1:0] position;
		logic [ste_pkg::CNT_W-1:0] removed;
		logic [ste_pkg::CNT_W-1:0] count;
	} table_answer_t;

	// Shadow copy of the table; only entries below shadow_fill are ever read.
	logic signed [ste_pkg::VAL_W-1:0] shadow_entries [DEPTH];
	int unsigned                      shadow_fill;
	table_answer_t                    answers_due [$];
	table_answer_t                    oldest_answer;
	int unsigned                      beat_errors;

	// Applies one request to the shadow table and returns the answer it must produce.
	function automatic table_answer_t apply_request(input ste_pkg::op_t op,
		input logic signed [ste_pkg::VAL_W-1:0] value,
		input logic [ste_pkg::IDX_W-1:0] index);
		table_answer_t ans;
		int            slot;
		int unsigned   wr;
		int unsigned   gone;
		ans = '{status: ste_pkg::ST_OK, position: '0, removed: '0, count: '0};
		case (op)
			ste_pkg::OP_INSERT: begin
				if (shadow_fill >= DEPTH) begin
					ans.status = ste_pkg::ST_FULL;
				end else begin
					// Walk down from the top, moving every larger entry up one place.
					slot = shadow_fill;
					while (slot >= 1 && shadow_entries[slot-1] > value) begin
						shadow_entries[slot] = shadow_entries[slot-1];
						slot--;
					end
					shadow_entries[slot] = value;
					shadow_fill++;
				end
			end
			ste_pkg::OP_DELETE: begin
				if (shadow_fill == 0) begin
					ans.status = ste_pkg::ST_EMPTY;
				end else begin
					// Compact out every entry equal to the value.
					wr = 0;
					gone = 0;
					for (slot = 0; slot < shadow_fill; slot++) begin
						if (shadow_entries[slot] != value) begin
							shadow_entries[wr] = shadow_entries[slot];
							wr++;
						end else begin
							gone++;
						end
					end
					if (gone == 0)
						ans.status = ste_pkg::ST_NOT_FOUND;
					else
						shadow_fill -= gone;
					ans.removed = ste_pkg::CNT_W'(gone);
				end
			end
			ste_pkg::OP_MODIFY: begin
				if (index >= 1 && index <= shadow_fill)
					shadow_entries[index-1] = value;
				else
					ans.status = ste_pkg::ST_BAD_INDEX;
			end
			default: begin
				// Query reports the first match only.
				ans.status = ste_pkg::ST_NOT_FOUND;
				for (slot = 0; slot < shadow_fill; slot++) begin
					if (shadow_entries[slot] == value) begin
						ans.position = ste_pkg::CNT_W'(slot + 1);
						ans.status = ste_pkg::ST_OK;
						break;
					end
				end
			end
		endcase
		ans.count = ste_pkg::CNT_W'(shadow_fill);
		return ans;
	endfunction

	// Reports one field that differs and returns how many mismatches it found.
	function automatic int unsigned field_differs(input string name,
		input logic [ste_pkg::CNT_W-1:0] want, input logic [ste_pkg::CNT_W-1:0] got);
		if (want !== got) begin
			$display("%0t: response %s mismatch, expected %0d, got %0d", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// Retire response beats against the oldest answer, then predict newly accepted requests.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_fill = 0;
			answers_due.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			beat_errors = 0;
			if (rsp.valid && rsp.ready) begin
				if (answers_due.size() == 0) begin
					$display("%0t: response beat with none due, expected nothing, got %0d/%0d/%0d/%0d",
						$time, rsp.status, rsp.position, rsp.removed, rsp.count);
					beat_errors++;
				end else begin
					oldest_answer = answers_due.pop_front();
					beat_errors += field_differs("status",
						ste_pkg::CNT_W'(oldest_answer.status), ste_pkg::CNT_W'(rsp.status));
					beat_errors += field_differs("position", oldest_answer.position,
						rsp.position);
					beat_errors += field_differs("removed", oldest_answer.removed, rsp.removed);
					beat_errors += field_differs("count", oldest_answer.count, rsp.count);
				end
			end
			if (req.valid && req.ready)
				answers_due.push_back(apply_request(ste_pkg::op_t'(req.op), req.value,
					req.index));
			fail_count <= fail_count + beat_errors;
			outstanding <= answers_due.size();
		end
	end

endmodule

/* verif/tb_sorted_table_engine_top.sv */
`timescale 1ns / 100ps

module tb_sorted_table_engine_top;

	localparam int unsigned DEPTH        = 16;
	localparam int unsigned RANDOM_ITEMS = 1150;
	localparam int unsigned PHASE_LEN    = 50;
	localparam int unsigned IDLE_LIMIT   = 5000;
	localparam int unsigned TAIL_CYCLES  = 40;
	localparam int unsigned HOLD_AT      = 3000;
	localparam int unsigned HOLD_LEN     = 400;

	localparam logic signed [ste_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [ste_pkg::VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	logic        clk;
	logic        arst_n;
	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned idle_cycles;
	int unsigned phase;

	// Small pool of values so that deletes and queries hit entries often.
	logic signed [ste_pkg::VAL_W-1:0] value_pool [8];

	ste_req_if req ();
	ste_rsp_if rsp ();

	sorted_table_engine_top #(
		.DEPTH(DEPTH)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	ste_table_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Some phases run the sender back to back; the others mix short and long gaps.
	function automatic int unsigned sender_gap();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (phase % 3 == 1)
			return 0;
		if (r < 5)
			return 0;
		if (r < 9)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [ste_pkg::VAL_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return value_pool[$urandom_range(0, 7)];
		if (r < 8)
			return $urandom;
		if (r == 8)
			return $signed($urandom_range(0, 40)) - 20;
		case ($urandom_range(0, 3))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return -1;
			default: return 0;
		endcase
	endfunction

	// Mostly plausible positions, sometimes the full width of the field.
	function automatic int unsigned pick_index();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(0, 17);
		return $urandom_range(0, 31);
	endfunction

	// The operation mix follows the phase: fill up, balanced, drain, then rewrite and search.
	function automatic ste_pkg::op_t pick_op(input int unsigned bias);
		int unsigned r;
		int unsigned t_ins;
		int unsigned t_del;
		int unsigned t_mod;
		r = $urandom_range(0, 99);
		case (bias)
			0: begin t_ins = 70; t_del = 80; t_mod = 90; end
			1: begin t_ins = 30; t_del = 55; t_mod = 75; end
			2: begin t_ins = 20; t_del = 65; t_mod = 80; end
			default: begin t_ins = 25; t_del = 40; t_mod = 70; end
		endcase
		if (r < t_ins)
			return ste_pkg::OP_INSERT;
		if (r < t_del)
			return ste_pkg::OP_DELETE;
		if (r < t_mod)
			return ste_pkg::OP_MODIFY;
		return ste_pkg::OP_QUERY;
	endfunction

	// Offers one request beat and returns once it is accepted, then idles for the gap.
	task automatic send_request(input ste_pkg::op_t op,
		input logic signed [ste_pkg::VAL_W-1:0] value, input int unsigned index);
		int unsigned gap;
		gap = sender_gap();
		req.valid <= 1'b1;
		req.op    <= op;
		req.value <= value;
		req.index <= ste_pkg::IDX_W'(index);
		do @(posedge clk); while (req.ready !== 1'b1);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Holds the sender off until every predicted answer has been seen.
	task automatic wait_drained();
		req.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Response side: random stalls, quiet stretches, and one long hold-off that fills the block.
	initial begin : rsp_side
		int unsigned rx_cycles;
		int unsigned stall_left;
		rsp.ready = 1'b0;
		rx_cycles = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			rx_cycles++;
			if (rx_cycles == HOLD_AT)
				stall_left = HOLD_LEN;
			if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else if ((rx_cycles / 600) % 4 == 3) begin
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= 1'b1;
				if ($urandom_range(0, 5) == 0)
					stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 4);
			end
		end
	end

	// Ends the run when no beat moves on either channel for too long.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : req_side
		int unsigned n;
		arst_n      = 1'b0;
		phase       = 0;
		req.valid   = 1'b0;
		req.op      = ste_pkg::OP_INSERT;
		req.value   = '0;
		req.index   = '0;
		value_pool  = '{0, -1, VAL_MIN, VAL_MAX, 1, -7, $urandom, $urandom};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Refusals on an empty table.
		send_request(ste_pkg::OP_DELETE, 5, 0);
		send_request(ste_pkg::OP_QUERY, 5, 0);
		send_request(ste_pkg::OP_MODIFY, 5, 1);
		// Extremes and a duplicate, which lands after its equal entry.
		send_request(ste_pkg::OP_INSERT, 0, 0);
		send_request(ste_pkg::OP_INSERT, VAL_MIN, 0);
		send_request(ste_pkg::OP_INSERT, VAL_MAX, 0);
		send_request(ste_pkg::OP_INSERT, 0, 31);
		send_request(ste_pkg::OP_QUERY, 0, 0);
		send_request(ste_pkg::OP_QUERY, VAL_MIN, 0);
		send_request(ste_pkg::OP_QUERY, 77, 0);
		// Modify at index zero, one past the count, the top of the field, and the last entry.
		send_request(ste_pkg::OP_MODIFY, 3, 0);
		send_request(ste_pkg::OP_MODIFY, 3, 5);
		send_request(ste_pkg::OP_MODIFY, 3, 31);
		send_request(ste_pkg::OP_MODIFY, 9, 4);
		// Break the order, then insert into the unordered table.
		send_request(ste_pkg::OP_MODIFY, VAL_MAX, 1);
		send_request(ste_pkg::OP_INSERT, -1, 0);
		// Delete of several equal entries, then a delete with no match.
		send_request(ste_pkg::OP_DELETE, VAL_MAX, 0);
		send_request(ste_pkg::OP_DELETE, 12345, 0);
		send_request(ste_pkg::OP_QUERY, -1, 0);
		send_request(ste_pkg::OP_DELETE, 0, 0);
		wait_drained();

		// Random phases of well-formed requests, with one pause until everything is answered.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			phase = n / PHASE_LEN;
			if (n == RANDOM_ITEMS / 2) begin
				wait_drained();
				repeat ($urandom_range(5, 30)) @(posedge clk);
			end
			send_request(pick_op(phase % 4), pick_value(), pick_index());
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/ste_pkg.sv
hw/rtl/ste_req_if.sv
hw/rtl/ste_rsp_if.sv
hw/rtl/ste_datapath.sv
hw/rtl/ste_ctrl.sv
hw/rtl/sorted_table_engine_top.sv
verif/ste_table_checker.sv
verif/tb_sorted_table_engine_top.sv
